// ===== src/dass_pkg.sv =====
// ----------------------------------------------------------------------------
// dass_pkg
// Shared types and constants of the dual-axis stroke sequencer.
// ----------------------------------------------------------------------------
package dass_pkg;

  // One-hot stroke phase of one axis
  typedef enum logic [6:0] {
    PH_IDLE       = 7'b0000001,
    PH_HOME       = 7'b0000010,
    PH_HOME_WAIT  = 7'b0000100,
    PH_HOME_DWELL = 7'b0001000,
    PH_RET        = 7'b0010000,
    PH_RET_WAIT   = 7'b0100000,
    PH_RET_DWELL  = 7'b1000000
  } phase_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_SYNC_MODE  = 3'd0,
    CFG_AXIS_FLAGS = 3'd1,
    CFG_X_STEPS    = 3'd2,
    CFG_Y_STEPS    = 3'd3,
    CFG_X_DWELL    = 3'd4,
    CFG_Y_DWELL    = 3'd5
  } cfg_index_t;

  localparam int unsigned CfgDataW = 24;
  localparam int unsigned StepsW   = 24;
  localparam int unsigned MoveW    = 25;
  localparam int unsigned DwellW   = 16;
  localparam int unsigned CountW   = 32;
  localparam int unsigned OffsetW  = 16;

  localparam logic [CountW-1:0] CountMax = 32'hFFFF_FFFF;

  typedef struct packed {
    logic tick_ms;
    logic start_x;
    logic stop_x;
    logic start_y;
    logic stop_y;
    logic x_idle;
    logic y_idle;
  } in_beat_t;

  typedef struct packed {
    logic              x_move;
    logic              x_dir;
    logic [MoveW-1:0]  x_steps;
    logic              y_move;
    logic              y_dir;
    logic [MoveW-1:0]  y_steps;
    logic              x_halt;
    logic              y_halt;
    logic [CountW-1:0] x_cycles;
    logic [CountW-1:0] y_cycles;
  } out_beat_t;

  // Result of one phase decision on a running axis
  typedef struct packed {
    phase_t            phase_next;
    logic              other_wr;
    phase_t            other_phase;
    logic [DwellW-1:0] dwell_next;
    logic [CountW-1:0] count_next;
    logic              move;
    logic              dir;
    logic [MoveW-1:0]  steps;
  } step_res_t;

endpackage

// ===== src/dass_axis_step.sv =====
// ----------------------------------------------------------------------------
// dass_axis_step
// One phase decision of a running axis, including the sync-mode handover.
// ----------------------------------------------------------------------------
module dass_axis_step (
  input  logic                          is_x,
  input  logic                          sync_mode,
  input  dass_pkg::phase_t              phase,
  input  logic [dass_pkg::DwellW-1:0]   dwell_left,
  input  logic [dass_pkg::CountW-1:0]   count,
  input  logic                          dir_bit,
  input  logic                          home_en,
  input  logic [dass_pkg::StepsW-1:0]   stroke_steps,
  input  logic [dass_pkg::DwellW-1:0]   dwell_ms,
  input  logic [dass_pkg::OffsetW-1:0]  home_offset,
  input  logic                          idle,
  output dass_pkg::step_res_t           res
);
  import dass_pkg::*;

  always_comb begin
    res             = '0;
    res.phase_next  = phase;
    res.other_phase = PH_IDLE;
    res.dwell_next  = dwell_left;
    res.count_next  = count;
    unique case (phase)
      PH_HOME: begin
        res.move       = 1'b1;
        res.dir        = dir_bit;
        res.steps      = MoveW'(stroke_steps)
                       + (home_en ? MoveW'(home_offset) : '0);
        res.phase_next = PH_HOME_WAIT;
      end
      PH_HOME_WAIT, PH_RET_WAIT: begin
        if (idle) begin
          res.dwell_next = dwell_ms;
          res.phase_next = (phase == PH_HOME_WAIT) ? PH_HOME_DWELL : PH_RET_DWELL;
        end
      end
      PH_HOME_DWELL: begin
        if (dwell_left == '0) begin
          if (sync_mode) begin
            res.other_wr    = 1'b1;
            res.other_phase = is_x ? PH_HOME : PH_RET;
            res.phase_next  = PH_IDLE;
          end else begin
            res.phase_next = PH_RET;
          end
        end
      end
      PH_RET: begin
        res.move       = 1'b1;
        res.dir        = ~dir_bit;
        res.steps      = MoveW'(stroke_steps);
        res.phase_next = PH_RET_WAIT;
      end
      PH_RET_DWELL: begin
        if (dwell_left == '0) begin
          if (count != CountMax) res.count_next = count + 1'b1;
          if (sync_mode) begin
            res.other_wr    = 1'b1;
            res.other_phase = is_x ? PH_RET : PH_HOME;
            res.phase_next  = PH_IDLE;
          end else begin
            res.phase_next = PH_HOME;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/dual_axis_stroke_sequencer.sv =====
// ----------------------------------------------------------------------------
// dual_axis_stroke_sequencer
// Home/return stroke sequencer for two stepper axes, X handled before Y.
// ----------------------------------------------------------------------------
// One input beat per poll, one result beat per poll. Each poll is resolved
// combinationally: the axis state registers are updated at the edge the
// input beat is accepted, and the result lands in the output register on
// that same edge, so the block takes a beat every cycle while its output
// register is empty or being read. The output register is the only buffer;
// while its beat is not taken, in_ready is low. Config writes go through
// cfg_we/cfg_index and are expected while no poll is in flight.
module dual_axis_stroke_sequencer #(
  parameter int unsigned HOME_OFFSET_STEPS = 200
) (
  input  logic                            clk,
  input  logic                            rst,
  // poll channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  dass_pkg::in_beat_t              in_data,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output dass_pkg::out_beat_t             out_data,
  // config write port
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_index,
  input  logic [dass_pkg::CfgDataW-1:0]   cfg_data
);
  import dass_pkg::*;

  localparam logic [OffsetW-1:0] HomeOffset = OffsetW'(HOME_OFFSET_STEPS);

  // config registers
  logic              sync_mode;
  logic [3:0]        axis_flags;
  logic [StepsW-1:0] x_stroke_steps, y_stroke_steps;
  logic [DwellW-1:0] x_dwell_ms, y_dwell_ms;

  // axis state
  logic              x_running, y_running;
  phase_t            x_phase, y_phase;
  logic [DwellW-1:0] x_dwell_left, y_dwell_left;
  logic [CountW-1:0] x_cycle_count, y_cycle_count;

  logic              x_running_next, y_running_next;
  phase_t            x_phase_next, y_phase_next;
  logic [DwellW-1:0] x_dwell_left_next, y_dwell_left_next;
  logic [CountW-1:0] x_cycle_count_next, y_cycle_count_next;

  logic              accept;
  logic [DwellW-1:0] x_dwell_tk, y_dwell_tk;   // after the ms tick
  phase_t            y_phase_mid;              // Y phase after the X pass
  step_res_t         x_res, y_res;
  out_beat_t         res_next;

  assign in_ready = ~out_valid | out_ready;
  assign accept   = in_valid & in_ready;

  // ms tick decrements nonzero dwell counters before any phase work
  assign x_dwell_tk = (in_data.tick_ms && x_dwell_left != '0) ? x_dwell_left - 1'b1
                                                              : x_dwell_left;
  assign y_dwell_tk = (in_data.tick_ms && y_dwell_left != '0) ? y_dwell_left - 1'b1
                                                              : y_dwell_left;

  dass_axis_step u_x_step (
    .is_x         (1'b1),
    .sync_mode    (sync_mode),
    .phase        (x_phase),
    .dwell_left   (x_dwell_tk),
    .count        (x_cycle_count),
    .dir_bit      (axis_flags[0]),
    .home_en      (axis_flags[2]),
    .stroke_steps (x_stroke_steps),
    .dwell_ms     (x_dwell_ms),
    .home_offset  (HomeOffset),
    .idle         (in_data.x_idle),
    .res          (x_res)
  );

  // Y sees the phase as X left it (sync handover may have just written it)
  dass_axis_step u_y_step (
    .is_x         (1'b0),
    .sync_mode    (sync_mode),
    .phase        (y_phase_mid),
    .dwell_left   (y_dwell_tk),
    .count        (y_cycle_count),
    .dir_bit      (axis_flags[1]),
    .home_en      (axis_flags[3]),
    .stroke_steps (y_stroke_steps),
    .dwell_ms     (y_dwell_ms),
    .home_offset  (HomeOffset),
    .idle         (in_data.y_idle),
    .res          (y_res)
  );

  // X pass then Y pass, in poll order
  logic   y_drop;
  logic   x_run_mid, y_run_mid;
  phase_t x_phase_mid;

  always_comb begin
    res_next           = '0;
    y_drop             = 1'b0;
    x_run_mid          = x_running;
    y_run_mid          = y_running;
    x_phase_mid        = x_phase;
    y_phase_mid        = y_phase;
    x_dwell_left_next  = x_dwell_tk;
    y_dwell_left_next  = y_dwell_tk;
    x_cycle_count_next = x_cycle_count;
    y_cycle_count_next = y_cycle_count;

    // axis X: stop beats start
    priority if (in_data.stop_x) begin
      x_phase_mid     = PH_IDLE;
      x_run_mid       = 1'b0;
      res_next.x_halt = 1'b1;
      if (sync_mode) begin
        y_phase_mid     = PH_IDLE;
        y_run_mid       = 1'b0;
        res_next.y_halt = 1'b1;
        y_drop          = 1'b1;
      end
    end else if (in_data.start_x) begin
      x_phase_mid = PH_HOME;
      x_run_mid   = 1'b1;
      if (sync_mode) begin
        y_phase_mid = PH_IDLE;
        y_run_mid   = 1'b1;
        y_drop      = 1'b1;
      end
    end else if (x_running) begin
      x_phase_mid        = x_res.phase_next;
      if (x_res.other_wr) y_phase_mid = x_res.other_phase;
      x_dwell_left_next  = x_res.dwell_next;
      x_cycle_count_next = x_res.count_next;
      res_next.x_move    = x_res.move;
      res_next.x_dir     = x_res.dir;
      res_next.x_steps   = x_res.steps;
    end else begin
    end

    x_running_next = x_run_mid;
    y_running_next = y_run_mid;
    x_phase_next   = x_phase_mid;
    y_phase_next   = y_phase_mid;

    // axis Y; a sync-mode X request swallows the Y request
    priority if (in_data.stop_y && !y_drop) begin
      y_phase_next    = PH_IDLE;
      y_running_next  = 1'b0;
      res_next.y_halt = 1'b1;
      if (sync_mode) begin
        x_phase_next    = PH_IDLE;
        x_running_next  = 1'b0;
        res_next.x_halt = 1'b1;
      end
    end else if (in_data.start_y && !y_drop) begin
      y_running_next = 1'b1;
      if (sync_mode) begin
        x_phase_next   = PH_HOME;
        y_phase_next   = PH_IDLE;
        x_running_next = 1'b1;
      end else begin
        y_phase_next = PH_HOME;
      end
    end else if (y_run_mid) begin
      y_phase_next       = y_res.phase_next;
      if (y_res.other_wr) x_phase_next = y_res.other_phase;
      y_dwell_left_next  = y_res.dwell_next;
      y_cycle_count_next = y_res.count_next;
      res_next.y_move    = y_res.move;
      res_next.y_dir     = y_res.dir;
      res_next.y_steps   = y_res.steps;
    end else begin
    end

    res_next.x_cycles = x_cycle_count_next;
    res_next.y_cycles = y_cycle_count_next;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_mode      <= 1'b0;
      axis_flags     <= '0;
      x_stroke_steps <= '0;
      y_stroke_steps <= '0;
      x_dwell_ms     <= '0;
      y_dwell_ms     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SYNC_MODE:  sync_mode      <= cfg_data[0];
        CFG_AXIS_FLAGS: axis_flags     <= cfg_data[3:0];
        CFG_X_STEPS:    x_stroke_steps <= cfg_data[StepsW-1:0];
        CFG_Y_STEPS:    y_stroke_steps <= cfg_data[StepsW-1:0];
        CFG_X_DWELL:    x_dwell_ms     <= cfg_data[DwellW-1:0];
        CFG_Y_DWELL:    y_dwell_ms     <= cfg_data[DwellW-1:0];
        default: begin
        end
      endcase
    end
  end

  // axis state, updated once per accepted poll
  always_ff @(posedge clk) begin
    if (rst) begin
      x_running     <= 1'b0;
      y_running     <= 1'b0;
      x_phase       <= PH_IDLE;
      y_phase       <= PH_IDLE;
      x_dwell_left  <= '0;
      y_dwell_left  <= '0;
      x_cycle_count <= '0;
      y_cycle_count <= '0;
    end else if (accept) begin
      x_running     <= x_running_next;
      y_running     <= y_running_next;
      x_phase       <= x_phase_next;
      y_phase       <= y_phase_next;
      x_dwell_left  <= x_dwell_left_next;
      y_dwell_left  <= y_dwell_left_next;
      x_cycle_count <= x_cycle_count_next;
      y_cycle_count <= y_cycle_count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res_next;
    end
  end

`ifndef ASSERT_OFF
  // every accepted poll leaves a result beat waiting
  a_accept_gives_beat: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted poll produced no result beat");

  // cycle counters only move up (saturating)
  a_x_count_mono: assert property (@(posedge clk) disable iff (rst)
    x_cycle_count >= $past(x_cycle_count))
    else $error("X cycle count went down");

  a_y_count_mono: assert property (@(posedge clk) disable iff (rst)
    y_cycle_count >= $past(y_cycle_count))
    else $error("Y cycle count went down");
`endif

endmodule

// ===== tb/sv/dual_axis_stroke_sequencer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_axis_stroke_sequencer_tb
// Self-checking bench for the two-axis home/return stroke sequencer.
// ----------------------------------------------------------------------------
// Polls go in on a valid/ready channel with random gaps. Each accepted poll
// is run through a cycle-free model of both axes kept in this file, and the
// predicted result beat is queued. A monitor pops the queue on every result
// beat and compares field by field. Configuration is rewritten between
// phases once the queue has drained: independent and sync mode, flag and
// stroke extremes, long dwells, a no-gap stretch and a long output stall.
// ----------------------------------------------------------------------------
module dual_axis_stroke_sequencer_tb;
  import dass_pkg::*;

  localparam int unsigned HomeOffset = 200;
  localparam int          QuietLimit = 2000;  // cycles with no beat on either side
  localparam int          HoldOff    = 300;   // receiver stall for the pressure test

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;
  logic      cfg_we;
  logic [2:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  dual_axis_stroke_sequencer #(
    .HOME_OFFSET_STEPS(HomeOffset)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Model copy of the configuration and of both axes
  // --------------------------------------------------------------------------
  logic                sync_cfg;
  logic [3:0]          flags_cfg;
  logic [StepsW-1:0]   x_steps_cfg, y_steps_cfg;
  logic [DwellW-1:0]   x_dwell_cfg, y_dwell_cfg;

  logic                x_run, y_run;
  phase_t              x_ph, y_ph;
  logic [DwellW-1:0]   x_dwell_left, y_dwell_left;
  logic [CountW-1:0]   x_count, y_count;

  out_beat_t axis_results_due[$];

  // bench bookkeeping
  int  mismatches;
  int  polls_sent;
  int  results_seen;
  int  moves_seen;
  int  halts_seen;
  int  settings_used;
  int  quiet_cycles;
  int  hold_cycles;
  bit  steady;  // no gaps on either side while set

  // One phase decision of a running axis. Launch outputs stay 0 unless a
  // stroke is launched on this poll.
  function automatic void advance_axis(
    input  bit                is_x,
    inout  phase_t            ph,
    inout  phase_t            other_ph,
    inout  logic [DwellW-1:0] dwell,
    inout  logic [CountW-1:0] cnt,
    input  logic              dir_bit,
    input  logic              home_en,
    input  logic [StepsW-1:0] steps,
    input  logic [DwellW-1:0] dwell_ms,
    input  logic              idle,
    output logic              mv,
    output logic              dir,
    output logic [MoveW-1:0]  nsteps
  );
    mv     = 1'b0;
    dir    = 1'b0;
    nsteps = '0;
    case (ph)
      PH_HOME: begin
        mv     = 1'b1;
        dir    = dir_bit;
        nsteps = MoveW'(steps) + (home_en ? MoveW'(HomeOffset) : MoveW'(0));
        ph     = PH_HOME_WAIT;
      end
      PH_HOME_WAIT, PH_RET_WAIT: begin
        if (idle) begin
          dwell = dwell_ms;
          ph    = (ph == PH_HOME_WAIT) ? PH_HOME_DWELL : PH_RET_DWELL;
        end
      end
      PH_HOME_DWELL: begin
        if (dwell == '0) begin
          if (sync_cfg) begin
            // hand over: X home -> Y home, Y home -> X return
            other_ph = is_x ? PH_HOME : PH_RET;
            ph       = PH_IDLE;
          end else begin
            ph = PH_RET;
          end
        end
      end
      PH_RET: begin
        mv     = 1'b1;
        dir    = ~dir_bit;
        nsteps = MoveW'(steps);
        ph     = PH_RET_WAIT;
      end
      PH_RET_DWELL: begin
        if (dwell == '0) begin
          if (cnt != CountMax) cnt = cnt + 1'b1;
          if (sync_cfg) begin
            other_ph = is_x ? PH_RET : PH_HOME;
            ph       = PH_IDLE;
          end else begin
            ph = PH_HOME;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Whole poll: tick, X requests/phase, then Y requests/phase.
  function automatic out_beat_t step_axes(in_beat_t b);
    out_beat_t r;
    logic x_stop, x_start, y_stop, y_start;
    r       = '0;
    x_stop  = b.stop_x;
    x_start = b.start_x & ~b.stop_x;   // stop wins on the same axis
    y_stop  = b.stop_y;
    y_start = b.start_y & ~b.stop_y;

    if (b.tick_ms) begin
      if (x_dwell_left != '0) x_dwell_left = x_dwell_left - 1'b1;
      if (y_dwell_left != '0) y_dwell_left = y_dwell_left - 1'b1;
    end

    // axis X; in sync mode an X request also owns Y and drops Y's request
    if (x_stop) begin
      x_ph     = PH_IDLE;
      r.x_halt = 1'b1;
      x_run    = 1'b0;
      if (sync_cfg) begin
        y_ph     = PH_IDLE;
        r.y_halt = 1'b1;
        y_run    = 1'b0;
        y_stop   = 1'b0;
        y_start  = 1'b0;
      end
    end else if (x_start) begin
      x_ph  = PH_HOME;
      x_run = 1'b1;
      if (sync_cfg) begin
        y_ph    = PH_IDLE;
        y_run   = 1'b1;
        y_stop  = 1'b0;
        y_start = 1'b0;
      end
    end else if (x_run) begin
      advance_axis(1'b1, x_ph, y_ph, x_dwell_left, x_count, flags_cfg[0], flags_cfg[2],
                   x_steps_cfg, x_dwell_cfg, b.x_idle, r.x_move, r.x_dir, r.x_steps);
    end

    // axis Y
    if (y_stop) begin
      y_ph     = PH_IDLE;
      r.y_halt = 1'b1;
      y_run    = 1'b0;
      if (sync_cfg) begin
        x_ph     = PH_IDLE;
        r.x_halt = 1'b1;
        x_run    = 1'b0;
      end
    end else if (y_start) begin
      if (sync_cfg) begin
        // sync start from Y: X leads with its home stroke
        x_ph  = PH_HOME;
        y_ph  = PH_IDLE;
        x_run = 1'b1;
        y_run = 1'b1;
      end else begin
        y_ph  = PH_HOME;
        y_run = 1'b1;
      end
    end else if (y_run) begin
      advance_axis(1'b0, y_ph, x_ph, y_dwell_left, y_count, flags_cfg[1], flags_cfg[3],
                   y_steps_cfg, y_dwell_cfg, b.y_idle, r.y_move, r.y_dir, r.y_steps);
    end

    r.x_cycles = x_count;
    r.y_cycles = y_count;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset, watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Any beat on either side restarts the count; a long silence is a hang.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("watchdog: no beat for %0d cycles, %0d results still due",
                 quiet_cycles, axis_results_due.size());
        $display("dual_axis_stroke_sequencer test failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random stalls, optional long hold-off
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int gap;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      gap = steady ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s, result %0d: expected %0h, got %0h",
                 name, results_seen, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    out_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (axis_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat with nothing due: %h", out_data);
      end else begin
        want = axis_results_due.pop_front();
        check_field("x_move",   32'(want.x_move),  32'(out_data.x_move));
        check_field("x_dir",    32'(want.x_dir),   32'(out_data.x_dir));
        check_field("x_steps",  32'(want.x_steps), 32'(out_data.x_steps));
        check_field("y_move",   32'(want.y_move),  32'(out_data.y_move));
        check_field("y_dir",    32'(want.y_dir),   32'(out_data.y_dir));
        check_field("y_steps",  32'(want.y_steps), 32'(out_data.y_steps));
        check_field("x_halt",   32'(want.x_halt),  32'(out_data.x_halt));
        check_field("y_halt",   32'(want.y_halt),  32'(out_data.y_halt));
        check_field("x_cycles", want.x_cycles,     out_data.x_cycles);
        check_field("y_cycles", want.y_cycles,     out_data.y_cycles);
        moves_seen += want.x_move + want.y_move;
        halts_seen += want.x_halt + want.y_halt;
      end
      results_seen++;
    end
  end

  // --------------------------------------------------------------------------
  // Poll side
  // --------------------------------------------------------------------------
  // Send one poll beat; valid stays up across back-to-back beats.
  task automatic send_poll(input in_beat_t b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    polls_sent++;
    axis_results_due.push_back(step_axes(b));
  endtask

  function automatic in_beat_t poll_of(logic tick, logic sx, logic px, logic sy, logic py,
                                       logic ix, logic iy);
    in_beat_t b;
    b.tick_ms = tick;
    b.start_x = sx;
    b.stop_x  = px;
    b.start_y = sy;
    b.stop_y  = py;
    b.x_idle  = ix;
    b.y_idle  = iy;
    return b;
  endfunction

  // Mostly plausible driver traffic with rare requests; some pure noise.
  function automatic in_beat_t random_poll();
    in_beat_t b;
    if ($urandom_range(0, 99) < 8) begin
      b = 7'($urandom_range(0, 127));
    end else begin
      b.tick_ms = $urandom_range(0, 1);
      b.start_x = ($urandom_range(0, 99) < 3);
      b.stop_x  = ($urandom_range(0, 99) < 2);
      b.start_y = ($urandom_range(0, 99) < 3);
      b.stop_y  = ($urandom_range(0, 99) < 2);
      b.x_idle  = ($urandom_range(0, 99) < 75);
      b.y_idle  = ($urandom_range(0, 99) < 75);
    end
    return b;
  endfunction

  task automatic run_random(input int n);
    send_poll(poll_of(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1));
    repeat (n - 1) send_poll(random_poll());
  endtask

  // Wait until every due result is in and the block has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (axis_results_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CfgDataW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    case (idx)
      CFG_SYNC_MODE:  sync_cfg    = v[0];
      CFG_AXIS_FLAGS: flags_cfg   = v[3:0];
      CFG_X_STEPS:    x_steps_cfg = v[StepsW-1:0];
      CFG_Y_STEPS:    y_steps_cfg = v[StepsW-1:0];
      CFG_X_DWELL:    x_dwell_cfg = v[DwellW-1:0];
      CFG_Y_DWELL:    y_dwell_cfg = v[DwellW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic sync, input logic [3:0] flags,
                            input logic [StepsW-1:0] xs, input logic [StepsW-1:0] ys,
                            input logic [DwellW-1:0] xd, input logic [DwellW-1:0] yd);
    settle();
    write_reg(CFG_SYNC_MODE,  CfgDataW'(sync));
    write_reg(CFG_AXIS_FLAGS, CfgDataW'(flags));
    write_reg(CFG_X_STEPS,    CfgDataW'(xs));
    write_reg(CFG_Y_STEPS,    CfgDataW'(ys));
    write_reg(CFG_X_DWELL,    CfgDataW'(xd));
    write_reg(CFG_Y_DWELL,    CfgDataW'(yd));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Random setting with short dwells so the loops actually turn over.
  task automatic random_config(input logic sync);
    set_config(sync, 4'($urandom_range(0, 15)),
               ($urandom_range(0, 1) != 0) ? 24'($urandom) : 24'($urandom_range(0, 15)),
               ($urandom_range(0, 1) != 0) ? 24'($urandom) : 24'($urandom_range(0, 15)),
               16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    // reset setting: nothing runs, all outputs quiet
    send_poll(poll_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));

    // independent: X homes toward 1 with offset and max stroke, Y zero stroke
    set_config(1'b0, 4'b0101, 24'hFF_FFFF, 24'h0, 16'h0, 16'h1);
    send_poll(poll_of(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));  // start both
    send_poll(poll_of(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));  // home launch
    send_poll(poll_of(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));  // drivers busy
    send_poll(poll_of(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));  // wait ends
    send_poll(poll_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));  // zero dwell ends, tick
    send_poll(poll_of(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));  // return launch
    send_poll(poll_of(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
    send_poll(poll_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
    send_poll(poll_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));  // home relaunch
    send_poll(poll_of(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));  // restart while running
    send_poll(poll_of(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1));  // stop beats start
    send_poll(poll_of(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1));  // stop beats start on Y

    // sync: Y homes toward 1 with offset and max stroke
    set_config(1'b1, 4'b1010, 24'h1, 24'hFF_FFFF, 16'h0, 16'h0);
    send_poll(poll_of(1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1));  // X start drops Y requests
    repeat (5) send_poll(poll_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
    send_poll(poll_of(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1));  // sync start from Y
    repeat (3) send_poll(poll_of(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
    send_poll(poll_of(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1));  // Y stop halts both
    send_poll(poll_of(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));  // X stop drops Y start
  endtask

  task automatic test_independent();
    repeat (3) begin
      random_config(1'b0);
      run_random(150);
    end
  endtask

  task automatic test_sync();
    repeat (3) begin
      random_config(1'b1);
      run_random(150);
    end
  endtask

  // Full-scale and zero strokes, one axis with the longest dwell, flags all set/clear
  task automatic test_extreme_config();
    set_config(1'b0, 4'hF, 24'hFF_FFFF, 24'hFF_FFFF, 16'hFFFF, 16'h0);
    run_random(100);
    set_config(1'b1, 4'h0, 24'h0, 24'hFF_FFFF, 16'h0, 16'hFFFF);
    run_random(100);
  endtask

  task automatic test_steady_stream();
    random_config(1'($urandom_range(0, 1)));
    steady = 1'b1;
    run_random(150);
    settle();
    steady = 1'b0;
  endtask

  // Receiver holds off while polls keep coming, so the input must stall.
  task automatic test_backpressure();
    random_config(1'($urandom_range(0, 1)));
    hold_cycles = HoldOff;
    run_random(150);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;

    sync_cfg     = 1'b0;
    flags_cfg    = '0;
    x_steps_cfg  = '0;
    y_steps_cfg  = '0;
    x_dwell_cfg  = '0;
    y_dwell_cfg  = '0;
    x_run        = 1'b0;
    y_run        = 1'b0;
    x_ph         = PH_IDLE;
    y_ph         = PH_IDLE;
    x_dwell_left = '0;
    y_dwell_left = '0;
    x_count      = '0;
    y_count      = '0;

    mismatches    = 0;
    polls_sent    = 0;
    results_seen  = 0;
    moves_seen    = 0;
    halts_seen    = 0;
    settings_used = 0;
    quiet_cycles  = 0;
    hold_cycles   = 0;
    steady        = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_independent();
    test_sync();
    test_extreme_config();
    test_steady_stream();
    test_backpressure();

    settle();
    repeat (5) @(posedge clk);

    $display("covered %0d polls over %0d settings (independent, sync, full-scale strokes)",
             polls_sent, settings_used);
    $display("results checked %0d: %0d strokes launched, %0d halts, cycles X %0d Y %0d",
             results_seen, moves_seen, halts_seen, x_count, y_count);
    if (mismatches == 0 && axis_results_due.size() == 0) begin
      $display("dual_axis_stroke_sequencer test passed");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches,
               axis_results_due.size());
      $display("dual_axis_stroke_sequencer test failed");
    end
    $finish;
  end

endmodule
